// File: rtl/sha256h_pkg.sv
// Shared types, initial hash values and round constants for the SHA-256 byte stream hasher.
`default_nettype none

package sha256h_pkg;

	typedef logic [31:0] word_t;

	// Round variables a..h
	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		word_t e;
		word_t f;
		word_t g;
		word_t h;
	} vars_t;

	// Message schedule taps for the current round: W[t], W[t+1], W[t+9], W[t+14]
	typedef struct packed {
		word_t w0;
		word_t w1;
		word_t w9;
		word_t w14;
	} sched_taps_t;

	localparam int unsigned BLOCK_BYTES = 64;
	localparam int unsigned DIGEST_BYTES = 32;
	localparam int unsigned LEN_FIELD_AT = 56;
	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam word_t H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic word_t round_k(input logic [5:0] t);
		word_t k;
		unique case (t)
			6'd0:  k = 32'h428a2f98;
			6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;
			6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;
			6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;
			6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;
			6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;
			6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;
			6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;
			6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;
			6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;
			6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;
			6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;
			6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;
			6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;
			6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;
			6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;
			6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;
			6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;
			6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;
			6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;
			6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;
			6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;
			6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;
			6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;
			6'd63: k = 32'hc67178f2;
			default: k = '0;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// File: rtl/sha256_byte_stream_hasher.sv
// Top level of the streaming SHA-256 hasher: byte buffer, padding and round sequencer.
//
// Input channel s_*: one beat per byte. s_tuser = 0 appends s_tdata to the message;
// s_tuser = 1 finishes the message (s_tdata ignored) and starts the digest.
// Output channel m_*: 32 digest beats, most significant byte of word 0 first,
// m_tlast high on the 32nd beat.
// The 64th byte of a block starts a compression (one round per cycle through the
// single round unit) and then folds the working variables into the hash; s_tready
// is low meanwhile. A finish beat feeds the padding and length bytes through the
// same byte path, one per cycle until the block is full (padding runs on into an
// extra block when more than 55 bytes were buffered), then compresses it. The digest
// then waits in the hash registers; each byte is shifted out when m_tready is high,
// and a stalled receiver simply holds the current beat. s_tready stays low until
// the last digest beat is taken, after which the hash returns to its initial values.
// Reset (arst_n low) loads the initial hash values and clears the byte count and
// length; the block buffer needs no reset.
`default_nettype none

module sha256_byte_stream_hasher (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] message_byte
	input  wire logic       s_tuser,   // [0] kind
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] digest_byte
	output logic            m_tlast    // last_byte
);
	import sha256h_pkg::*;

	localparam int unsigned BLOCK_BITS = BLOCK_BYTES * 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [5:0]         fill_q;
	logic [60:0]        len_q;
	logic [5:0]         round_q;
	logic [4:0]         out_cnt_q;
	logic               fin_q;
	logic               lenok_q;
	word_t              hash_q [8];
	logic [BLOCK_BITS-1:0] blk_q;
	vars_t              vars_q;

	logic               s_acc;
	logic               m_acc;
	logic               byte_en;
	logic [7:0]         byte_val;
	logic               start_comp;
	logic [63:0]        bit_len;
	logic [7:0]         len_byte;
	logic               in_len_field;
	sched_taps_t        taps;
	vars_t              vars_next;
	word_t              w_next;
	vars_t              hash_vars;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tdata  = hash_q[0][31:24];
	assign m_tlast  = (out_cnt_q == 5'(DIGEST_BYTES - 1));

	assign s_acc = s_tvalid & s_tready;
	assign m_acc = m_tvalid & m_tready;

	// Length field goes out most significant byte first at positions 56..63
	assign bit_len      = {len_q, 3'b000};
	assign len_byte     = bit_len[{~fill_q[2:0], 3'b000} +: 8];
	assign in_len_field = (fill_q >= 6'(LEN_FIELD_AT));

	always_comb begin
		byte_en  = 1'b0;
		byte_val = '0;
		if (state_q == ST_IDLE && s_acc) begin
			byte_en  = 1'b1;
			byte_val = s_tuser ? PAD_MARK : s_tdata;
		end else if (state_q == ST_PAD) begin
			byte_en  = 1'b1;
			byte_val = (lenok_q && in_len_field) ? len_byte : 8'h00;
		end
	end

	assign start_comp = byte_en && (fill_q == 6'(BLOCK_BYTES - 1));

	// Words sit in order from the top of the buffer; word 0 is the first word of the block
	assign taps.w0  = blk_q[BLOCK_BITS-1      -: 32];
	assign taps.w1  = blk_q[BLOCK_BITS-1-32   -: 32];
	assign taps.w9  = blk_q[BLOCK_BITS-1-9*32 -: 32];
	assign taps.w14 = blk_q[BLOCK_BITS-1-14*32 -: 32];

	assign hash_vars = '{a: hash_q[0], b: hash_q[1], c: hash_q[2], d: hash_q[3],
		e: hash_q[4], f: hash_q[5], g: hash_q[6], h: hash_q[7]};

	sha256h_round u_round (
		.vars      (vars_q),
		.taps      (taps),
		.k         (round_k(round_q)),
		.vars_next (vars_next),
		.w_next    (w_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			len_q     <= '0;
			round_q   <= '0;
			out_cnt_q <= '0;
			fin_q     <= 1'b0;
			lenok_q   <= 1'b0;
			for (int j = 0; j < 8; j++) begin
				hash_q[j] <= H_INIT[j];
			end
		end else begin
			if (byte_en) begin
				fill_q <= fill_q + 6'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						fin_q <= s_tuser;
						// length bytes fit in this block only if the mark lands before them
						lenok_q <= (fill_q < 6'(LEN_FIELD_AT));
						if (!s_tuser) begin
							len_q <= len_q + 61'd1;
						end
						if (start_comp) begin
							round_q <= '0;
							state_q <= ST_ROUND;
						end else if (s_tuser) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (start_comp) begin
						round_q <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'(BLOCK_BYTES - 1)) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					hash_q[0] <= hash_q[0] + vars_q.a;
					hash_q[1] <= hash_q[1] + vars_q.b;
					hash_q[2] <= hash_q[2] + vars_q.c;
					hash_q[3] <= hash_q[3] + vars_q.d;
					hash_q[4] <= hash_q[4] + vars_q.e;
					hash_q[5] <= hash_q[5] + vars_q.f;
					hash_q[6] <= hash_q[6] + vars_q.g;
					hash_q[7] <= hash_q[7] + vars_q.h;
					if (!fin_q) begin
						state_q <= ST_IDLE;
					end else if (lenok_q) begin
						out_cnt_q <= '0;
						state_q   <= ST_EMIT;
					end else begin
						// overflow block done: pad a fresh block with zeros and the length
						lenok_q <= 1'b1;
						state_q <= ST_PAD;
					end
				end
				ST_EMIT: begin
					if (m_acc) begin
						out_cnt_q <= out_cnt_q + 5'd1;
						if (m_tlast) begin
							for (int j = 0; j < 8; j++) begin
								hash_q[j] <= H_INIT[j];
							end
							len_q   <= '0;
							fill_q  <= '0;
							fin_q   <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							for (int j = 0; j < 7; j++) begin
								hash_q[j] <= {hash_q[j][23:0], hash_q[j+1][31:24]};
							end
							hash_q[7] <= {hash_q[7][23:0], 8'h00};
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Buffer doubles as the rolling message schedule during the rounds
	always_ff @(posedge clk) begin
		if (byte_en) begin
			blk_q <= {blk_q[BLOCK_BITS-9:0], byte_val};
		end else if (state_q == ST_ROUND) begin
			blk_q <= {blk_q[BLOCK_BITS-33:0], w_next};
		end
		if (start_comp) begin
			vars_q <= hash_vars;
		end else if (state_q == ST_ROUND) begin
			vars_q <= vars_next;
		end
	end

endmodule

`default_nettype wire

// File: rtl/sha256h_round.sv
// One SHA-256 round and one message schedule expansion step, shared by all 64 rounds.
`default_nettype none

module sha256h_round (
	input  wire sha256h_pkg::vars_t       vars,
	input  wire sha256h_pkg::sched_taps_t taps,
	input  wire sha256h_pkg::word_t       k,
	output sha256h_pkg::vars_t            vars_next,
	output sha256h_pkg::word_t            w_next
);
	import sha256h_pkg::*;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	word_t big_s0;
	word_t big_s1;
	word_t ch;
	word_t maj;
	word_t t1;
	word_t t2;
	word_t sm_s0;
	word_t sm_s1;

	assign big_s1 = rotr(vars.e, 6) ^ rotr(vars.e, 11) ^ rotr(vars.e, 25);
	assign big_s0 = rotr(vars.a, 2) ^ rotr(vars.a, 13) ^ rotr(vars.a, 22);
	assign ch     = (vars.e & vars.f) ^ (~vars.e & vars.g);
	assign maj    = (vars.a & vars.b) ^ (vars.a & vars.c) ^ (vars.b & vars.c);
	assign t1     = vars.h + big_s1 + ch + k + taps.w0;
	assign t2     = big_s0 + maj;

	always_comb begin
		vars_next.h = vars.g;
		vars_next.g = vars.f;
		vars_next.f = vars.e;
		vars_next.e = vars.d + t1;
		vars_next.d = vars.c;
		vars_next.c = vars.b;
		vars_next.b = vars.a;
		vars_next.a = t1 + t2;
	end

	// Schedule word W[t+16], computed while round t runs
	assign sm_s0  = rotr(taps.w1, 7) ^ rotr(taps.w1, 18) ^ (taps.w1 >> 3);
	assign sm_s1  = rotr(taps.w14, 17) ^ rotr(taps.w14, 19) ^ (taps.w14 >> 10);
	assign w_next = taps.w0 + sm_s0 + taps.w9 + sm_s1;

endmodule

`default_nettype wire
